@@ hdl/icn_pkg.sv @@
// Shared constants for the idle cursor nudge generator.
// Holds register indexes, reset values, widths and pattern codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icn_pkg;

   // Coordinate width default for the top level
   localparam int COORD_BITS_DEFAULT = 16;

   // Register widths
   localparam int IDLE_WAIT_W = 13;
   localparam int STEP_DIST_W = 7;
   localparam int SCREEN_W    = 15;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_ADDR_W  = 2;
   localparam int TIME_W      = 32;
   localparam int STEP_W      = 8;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_IDLE_WAIT     = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STEP_DISTANCE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

   // Register reset values
   localparam logic [IDLE_WAIT_W-1:0] IDLE_WAIT_RESET = 13'd30;
   localparam logic [STEP_DIST_W-1:0] STEP_DIST_RESET = 7'd5;
   localparam logic [SCREEN_W-1:0]    WIDTH_RESET     = 15'd1920;
   localparam logic [SCREEN_W-1:0]    HEIGHT_RESET    = 15'd1080;

   // Item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Nudge patterns
   localparam logic [1:0] PAT_HORIZONTAL = 2'd0;
   localparam logic [1:0] PAT_VERTICAL   = 2'd1;
   localparam logic [1:0] PAT_DIAGONAL   = 2'd2;
   localparam logic [1:0] PAT_LAST       = PAT_DIAGONAL;

   // Distance from a screen edge at which an axis turns around
   localparam int EDGE_MARGIN = 10;

endpackage : icn_pkg

`default_nettype wire

@@ hdl/idle_cursor_nudge_generator.sv @@
// Idle cursor nudge generator: input register, single-pass decision logic,
// output register. Depends on icn_pkg for constants and register indexes.
`timescale 1ns / 1ps
`default_nettype none

//  channel | ports                    | direction | handshake
//  --------+--------------------------+-----------+-------------------
//  req     | kind, cursor, now        | in        | req_valid/ready
//  rsp     | move, step, user_active  | out       | rsp_valid/ready
//  csr     | wen, addr, wdata         | in        | write on csr_wen
//
// One item per cycle sustained while rsp is ready: an item waits in the
// input register, where the decision logic updates state and loads the
// output register, which drives the result on rsp.
// Synchronous reset clears valids and state and sets the configuration registers to defaults.
// A stalled rsp holds the output register; the input register keeps
// accepting while the output register is free or drains, and reports pass
// through without needing it.
module idle_cursor_nudge_generator #(
   parameter int COORD_BITS = icn_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic signed [COORD_BITS-1:0]  req_cursor_x,
   input  wire logic signed [COORD_BITS-1:0]  req_cursor_y,
   input  wire logic [icn_pkg::TIME_W-1:0]    req_now_seconds,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_move_issued,
   output logic signed [icn_pkg::STEP_W-1:0]  rsp_step_x,
   output logic signed [icn_pkg::STEP_W-1:0]  rsp_step_y,
   output logic                               rsp_user_active,
   // configuration
   input  wire logic                          csr_wen,
   input  wire logic [icn_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [icn_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import icn_pkg::*;

   localparam int SUM_W = ((COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W) + 2;
   localparam logic signed [SUM_W-1:0] MARGIN_S = SUM_W'(EDGE_MARGIN);

   // configuration registers
   logic [IDLE_WAIT_W-1:0] idle_wait_ff;
   logic [STEP_DIST_W-1:0] step_dist_ff;
   logic [SCREEN_W-1:0]    width_ff;
   logic [SCREEN_W-1:0]    height_ff;

   // input register
   logic                   s1_valid_ff;
   logic                   s1_kind_ff;
   logic [COORD_BITS-1:0]  s1_x_ff;
   logic [COORD_BITS-1:0]  s1_y_ff;
   logic [TIME_W-1:0]      s1_now_ff;

   // block state
   logic [COORD_BITS-1:0]  last_x_ff, last_x_in;
   logic [COORD_BITS-1:0]  last_y_ff, last_y_in;
   logic [TIME_W-1:0]      act_time_ff, act_time_in;
   logic                   waiting_ff, waiting_in;
   logic [1:0]             pattern_ff, pattern_in;
   logic                   x_rev_ff, x_rev_in;
   logic                   y_rev_ff, y_rev_in;

   // output register
   logic                   out_valid_ff;
   logic                   out_move_ff, out_move_in;
   logic [STEP_W-1:0]      out_dx_ff, out_dx_in;
   logic [STEP_W-1:0]      out_dy_ff, out_dy_in;
   logic                   out_active_ff, out_active_in;

   // handshake control
   logic out_free;
   logic s1_fire;
   logic s1_result;

   // decision terms
   logic                    moved;
   logic [TIME_W-1:0]       elapsed;
   logic                    still_waiting;
   logic [STEP_W-1:0]       d_pos, d_neg;
   logic [STEP_W-1:0]       dx_pre, dy_pre;
   logic signed [SUM_W-1:0] sum_x, sum_y, hi_x, hi_y;
   logic                    edge_x, edge_y;
   logic                    x_dir, y_dir;
   logic                    wrap;

   // advance the pipeline
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s1_result = (s1_kind_ff == KIND_SAMPLE);
   assign s1_fire   = s1_valid_ff && (!s1_result || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;

   // step magnitudes in both directions
   assign d_pos = {1'b0, step_dist_ff};
   assign d_neg = STEP_W'(0) - d_pos;

   // decide activity, wait and step for the item in the input register
   always_comb begin
      moved         = (s1_x_ff != last_x_ff) || (s1_y_ff != last_y_ff);
      elapsed       = s1_now_ff - act_time_ff;
      still_waiting = waiting_ff && (elapsed < TIME_W'(idle_wait_ff));

      // step before edge checks
      unique case (pattern_ff)
         PAT_VERTICAL: begin
            dx_pre = '0;
            dy_pre = y_rev_ff ? d_neg : d_pos;
         end
         PAT_DIAGONAL: begin
            dx_pre = x_rev_ff ? d_neg : d_pos;
            dy_pre = y_rev_ff ? d_neg : d_pos;
         end
         default: begin
            dx_pre = x_rev_ff ? d_neg : d_pos;
            dy_pre = '0;
         end
      endcase

      // bounce off the screen margins
      sum_x  = {{(SUM_W-COORD_BITS){s1_x_ff[COORD_BITS-1]}}, s1_x_ff}
             + {{(SUM_W-STEP_W){dx_pre[STEP_W-1]}}, dx_pre};
      sum_y  = {{(SUM_W-COORD_BITS){s1_y_ff[COORD_BITS-1]}}, s1_y_ff}
             + {{(SUM_W-STEP_W){dy_pre[STEP_W-1]}}, dy_pre};
      hi_x   = {{(SUM_W-SCREEN_W){1'b0}}, width_ff} - MARGIN_S;
      hi_y   = {{(SUM_W-SCREEN_W){1'b0}}, height_ff} - MARGIN_S;
      edge_x = (sum_x < MARGIN_S) || (sum_x > hi_x);
      edge_y = (sum_y < MARGIN_S) || (sum_y > hi_y);
      x_dir  = x_rev_ff ^ edge_x;
      y_dir  = y_rev_ff ^ edge_y;
      wrap   = (pattern_ff >= PAT_LAST);

      // defaults: hold state
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      act_time_in   = act_time_ff;
      waiting_in    = waiting_ff;
      pattern_in    = pattern_ff;
      x_rev_in      = x_rev_ff;
      y_rev_in      = y_rev_ff;
      out_move_in   = 1'b0;
      out_dx_in     = '0;
      out_dy_in     = '0;
      out_active_in = 1'b0;

      priority if (!s1_result) begin
         // position report: remember it only
         last_x_in = s1_x_ff;
         last_y_in = s1_y_ff;
      end else if (moved) begin
         // user moved the cursor: restart the wait
         last_x_in     = s1_x_ff;
         last_y_in     = s1_y_ff;
         act_time_in   = s1_now_ff;
         waiting_in    = 1'b1;
         out_active_in = 1'b1;
      end else if (still_waiting) begin
         out_active_in = 1'b1;
      end else begin
         // issue a nudge and advance the pattern
         waiting_in  = 1'b0;
         out_move_in = 1'b1;
         out_dx_in   = edge_x ? (x_dir ? d_neg : d_pos) : dx_pre;
         out_dy_in   = edge_y ? (y_dir ? d_neg : d_pos) : dy_pre;
         pattern_in  = wrap ? PAT_HORIZONTAL : pattern_ff + 2'd1;
         x_rev_in    = x_dir ^ wrap;
         y_rev_in    = y_dir ^ wrap;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_wait_ff <= IDLE_WAIT_RESET;
         step_dist_ff <= STEP_DIST_RESET;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
      end else if (csr_wen) begin
         unique case (csr_addr)
            REG_IDLE_WAIT:     idle_wait_ff <= csr_wdata[IDLE_WAIT_W-1:0];
            REG_STEP_DISTANCE: step_dist_ff <= csr_wdata[STEP_DIST_W-1:0];
            REG_SCREEN_WIDTH:  width_ff     <= csr_wdata[SCREEN_W-1:0];
            REG_SCREEN_HEIGHT: height_ff    <= csr_wdata[SCREEN_W-1:0];
            default: ;
         endcase
      end
   end

   // input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_kind_ff <= req_kind;
         s1_x_ff    <= req_cursor_x;
         s1_y_ff    <= req_cursor_y;
         s1_now_ff  <= req_now_seconds;
      end
   end

   // block state update
   always_ff @(posedge clock) begin
      if (reset) begin
         last_x_ff   <= '1;
         last_y_ff   <= '1;
         act_time_ff <= '0;
         waiting_ff  <= 1'b0;
         pattern_ff  <= PAT_HORIZONTAL;
         x_rev_ff    <= 1'b0;
         y_rev_ff    <= 1'b0;
      end else if (s1_fire) begin
         last_x_ff   <= last_x_in;
         last_y_ff   <= last_y_in;
         act_time_ff <= act_time_in;
         waiting_ff  <= waiting_in;
         pattern_ff  <= pattern_in;
         x_rev_ff    <= x_rev_in;
         y_rev_ff    <= y_rev_in;
      end
   end

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= s1_fire && s1_result;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (s1_fire && s1_result) begin
         out_move_ff   <= out_move_in;
         out_dx_ff     <= out_dx_in;
         out_dy_ff     <= out_dy_in;
         out_active_ff <= out_active_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_move_issued = out_move_ff;
   assign rsp_step_x      = out_dx_ff;
   assign rsp_step_y      = out_dy_ff;
   assign rsp_user_active = out_active_ff;

endmodule : idle_cursor_nudge_generator

`default_nettype wire
